// ===== sv/mcm9_pkg.sv =====
// Shared types and constants for the multichannel median-of-nine filter.
package mcm9_pkg;

	localparam int unsigned ChanBits  = 3;
	localparam int unsigned FieldBits = 12;
	localparam int unsigned RingLen   = 9;
	localparam int unsigned SlotBits  = 4;
	localparam int unsigned NetSteps  = 19;

	typedef logic [SlotBits-1:0] slot_t;

	// Compare-exchange pairs of the median-of-nine network, in order.
	localparam slot_t NetLo [NetSteps] = '{
		4'd1, 4'd4, 4'd7, 4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd0,
		4'd5, 4'd4, 4'd3, 4'd1, 4'd2, 4'd4, 4'd4, 4'd6, 4'd4
	};
	localparam slot_t NetHi [NetSteps] = '{
		4'd2, 4'd5, 4'd8, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8, 4'd3,
		4'd8, 4'd7, 4'd6, 4'd4, 4'd5, 4'd7, 4'd2, 4'd4, 4'd2
	};

	typedef struct packed {
		logic [ChanBits-1:0]  channel;
		logic [FieldBits-1:0] sample;
	} in_t;

	typedef struct packed {
		logic [ChanBits-1:0]  channel_out;
		logic [FieldBits-1:0] median;
	} out_t;

endpackage

// ===== sv/mcm9_ring_store.sv =====
// Per-channel rings of the nine latest samples, write slots, and row read with new sample merged.
module mcm9_ring_store #(
	parameter int unsigned CHANNELS    = 7,
	parameter int unsigned SAMPLE_BITS = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [mcm9_pkg::ChanBits-1:0]     channel,
	input  logic [SAMPLE_BITS-1:0]            sample,
	output logic                              good,
	output logic [SAMPLE_BITS-1:0]            row_upd [mcm9_pkg::RingLen]
);

	localparam int unsigned ChIdxBits = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic [SAMPLE_BITS-1:0] rows_q [CHANNELS][mcm9_pkg::RingLen];
	mcm9_pkg::slot_t        slot_q [CHANNELS];
	logic [ChIdxBits-1:0]   ch_idx;
	mcm9_pkg::slot_t        cur_slot;
	mcm9_pkg::slot_t        nxt_slot;

	assign good     = ({1'b0, channel} < (mcm9_pkg::ChanBits + 1)'(CHANNELS));
	assign ch_idx   = channel[ChIdxBits-1:0];
	assign cur_slot = slot_q[ch_idx];
	assign nxt_slot = (cur_slot >= mcm9_pkg::slot_t'(mcm9_pkg::RingLen - 1)) ?
		'0 : cur_slot + mcm9_pkg::slot_t'(1);

	// Row as it stands after this item's write; the top level registers it in stage 1 before sorting.
	always_comb begin
		for (int j = 0; j < mcm9_pkg::RingLen; j++) begin
			row_upd[j] = (mcm9_pkg::slot_t'(j) == cur_slot) ? sample : rows_q[ch_idx][j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				slot_q[c] <= '0;
				for (int j = 0; j < mcm9_pkg::RingLen; j++) begin
					rows_q[c][j] <= '0;
				end
			end
		end else if (wr_en && good) begin
			rows_q[ch_idx][cur_slot] <= sample;
			slot_q[ch_idx]           <= nxt_slot;
		end
	end

endmodule

// ===== sv/mcm9_sort_net.sv =====
// Median-of-nine compare-exchange network (combinational).
module mcm9_sort_net #(
	parameter int unsigned SAMPLE_BITS = 12
) (
	input  logic [SAMPLE_BITS-1:0] vals [mcm9_pkg::RingLen],
	output logic [SAMPLE_BITS-1:0] median
);

	logic [SAMPLE_BITS-1:0] st [mcm9_pkg::NetSteps+1][mcm9_pkg::RingLen];

	for (genvar j = 0; j < mcm9_pkg::RingLen; j++) begin : g_in
		assign st[0][j] = vals[j];
	end

	for (genvar k = 0; k < mcm9_pkg::NetSteps; k++) begin : g_step
		localparam int Lo = int'(mcm9_pkg::NetLo[k]);
		localparam int Hi = int'(mcm9_pkg::NetHi[k]);
		logic swap;
		assign swap = st[k][Lo] > st[k][Hi];
		for (genvar j = 0; j < mcm9_pkg::RingLen; j++) begin : g_el
			if (j == Lo) begin : g_lo
				assign st[k+1][j] = swap ? st[k][Hi] : st[k][Lo];
			end else if (j == Hi) begin : g_hi
				assign st[k+1][j] = swap ? st[k][Lo] : st[k][Hi];
			end else begin : g_pass
				assign st[k+1][j] = st[k][j];
			end
		end
	end

	assign median = st[mcm9_pkg::NetSteps][4];

endmodule

// ===== sv/multichannel_median_of_nine_unit.sv =====
// Top level: multichannel median-of-nine filter.
// Pipeline: the ring read/merge of an accepted item goes into the stage-1 register,
// then the sort network output into the result register; result_stall can hold both.
// Throughput: one item per cycle unless stalled; ring store written at the accept edge.
// Reset clears all ring samples to zero, all write slots, and both valid flags.
module multichannel_median_of_nine_unit #(
	parameter int unsigned CHANNELS    = 7,
	parameter int unsigned SAMPLE_BITS = 12
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           sample_valid,
	output logic           sample_stall,
	input  mcm9_pkg::in_t  sample_data,
	output logic           result_valid,
	input  logic           result_stall,
	output mcm9_pkg::out_t result_data
);

	localparam int unsigned WideBits = (SAMPLE_BITS > mcm9_pkg::FieldBits) ?
		SAMPLE_BITS : mcm9_pkg::FieldBits;

	logic                              accept;
	logic                              adv_s2;
	logic                              adv_s1;
	logic [WideBits-1:0]               smp_wide;
	logic [SAMPLE_BITS-1:0]            smp;
	logic                              good;
	logic [SAMPLE_BITS-1:0]            row_upd [mcm9_pkg::RingLen];

	logic                              valid_s1;
	logic                              good_s1;
	logic [mcm9_pkg::ChanBits-1:0]     chan_s1;
	logic [SAMPLE_BITS-1:0]            row_s1 [mcm9_pkg::RingLen];

	logic [SAMPLE_BITS-1:0]            med;
	logic [WideBits-1:0]               med_wide;
	logic                              valid_s2;
	mcm9_pkg::out_t                    data_s2;

	// Result register frees when empty or taken; stage 1 moves when it can.
	assign adv_s2       = !valid_s2 || !result_stall;
	assign adv_s1       = !valid_s1 || adv_s2;
	assign sample_stall = !adv_s1;
	assign accept       = sample_valid && adv_s1;

	assign smp_wide = WideBits'(sample_data.sample);
	assign smp      = smp_wide[SAMPLE_BITS-1:0];

	mcm9_ring_store #(
		.CHANNELS    (CHANNELS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept),
		.channel (sample_data.channel),
		.sample  (smp),
		.good    (good),
		.row_upd (row_upd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			good_s1 <= good;
			chan_s1 <= sample_data.channel;
			for (int j = 0; j < mcm9_pkg::RingLen; j++) begin
				row_s1[j] <= row_upd[j];
			end
		end
	end

	mcm9_sort_net #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_net (
		.vals   (row_s1),
		.median (med)
	);

	assign med_wide = WideBits'(med);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			data_s2.channel_out <= chan_s1;
			data_s2.median      <= good_s1 ? med_wide[mcm9_pkg::FieldBits-1:0] : '0;
		end
	end

	assign result_valid = valid_s2;
	assign result_data  = data_s2;

	// A channel outside the configured range always reports a zero median.
	a_bad_chan_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && ({1'b0, result_data.channel_out} >=
			(mcm9_pkg::ChanBits + 1)'(CHANNELS))) |-> (result_data.median == '0))
		else $error("bad channel gave nonzero median");

	// An accepted item always lands in stage 1.
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && !sample_stall) |=> valid_s1)
		else $error("accepted item lost before stage 1");

	// While the result is held, a waiting stage-1 item is kept.
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall && valid_s1) |=> (valid_s1 && $stable(chan_s1)))
		else $error("stage-1 item dropped under output stall");

endmodule
